FILE: hdl/assert_macros.svh
// Assertion macros for the event parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during rst.
`define GREP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grep assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define GREP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grep assertion failed");

`else

`define GREP_ASSERT_NOW(lbl, ante, cons)
`define GREP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/grep_pkg.sv
`default_nettype none

package grep_pkg;

  localparam logic [7:0] CMD_GRID_UP    = 8'h20;
  localparam logic [7:0] CMD_GRID_DOWN  = 8'h21;
  localparam logic [7:0] CMD_RING_DELTA = 8'h50;
  localparam logic [7:0] CMD_RING_UP    = 8'h51;
  localparam logic [7:0] CMD_RING_DOWN  = 8'h52;

  localparam logic [1:0] KIND_GRID_KEY   = 2'd0;
  localparam logic [1:0] KIND_RING_DELTA = 2'd1;
  localparam logic [1:0] KIND_RING_KEY   = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_transfer;
  } rx_word_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [7:0]        pos_x;
    logic [7:0]        pos_y;
    logic signed [7:0] event_value;
  } ev_word_t;

endpackage

`default_nettype wire

FILE: hdl/grep_decode.sv
`default_nettype none

module grep_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire grep_pkg::rx_word_t rx_in,
  output logic                    hit,
  output grep_pkg::ev_word_t      ev
);
  import grep_pkg::*;

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_ARG1 = 2'd1;
  localparam logic [1:0] PH_ARG2 = 2'd2;

  logic [1:0] phase, phase_next;
  logic [7:0] command, command_next;
  logic [7:0] first_arg, first_arg_next;
  logic       discarding, discarding_next;

  logic [7:0] b;
  logic       eot;
  logic       ring_key_cmd, two_arg_cmd;

  assign b   = rx_in.rx_byte;
  assign eot = rx_in.end_of_transfer;

  assign ring_key_cmd = (command == CMD_RING_UP) || (command == CMD_RING_DOWN);
  assign two_arg_cmd  = (command == CMD_GRID_UP) || (command == CMD_GRID_DOWN)
                        || (command == CMD_RING_DELTA);

  always_comb begin
    phase_next      = phase;
    command_next    = command;
    first_arg_next  = first_arg;
    discarding_next = discarding;
    hit             = 1'b0;
    ev              = '0;

    if (!discarding) begin
      case (phase)
        PH_ARG1: begin
          if (ring_key_cmd) begin
            hit            = 1'b1;
            ev.event_kind  = KIND_RING_KEY;
            ev.pos_x       = b;
            ev.event_value = (command == CMD_RING_DOWN) ? 8'sd1 : 8'sd0;
            phase_next     = PH_CMD;
          end else if (two_arg_cmd) begin
            first_arg_next = b;
            phase_next     = PH_ARG2;
          end else begin
            phase_next = PH_CMD;
          end
        end
        PH_ARG2: begin
          if ((command == CMD_GRID_UP) || (command == CMD_GRID_DOWN)) begin
            hit            = 1'b1;
            ev.event_kind  = KIND_GRID_KEY;
            ev.pos_x       = first_arg;
            ev.pos_y       = b;
            ev.event_value = (command == CMD_GRID_DOWN) ? 8'sd1 : 8'sd0;
          end else if (command == CMD_RING_DELTA) begin
            hit            = 1'b1;
            ev.event_kind  = KIND_RING_DELTA;
            ev.pos_x       = first_arg;
            ev.event_value = signed'(b);
          end
          phase_next = PH_CMD;
        end
        default: begin
          if (b inside {CMD_GRID_UP, CMD_GRID_DOWN, CMD_RING_DELTA,
                        CMD_RING_UP, CMD_RING_DOWN}) begin
            command_next = b;
            phase_next   = PH_ARG1;
          end else begin
            phase_next      = PH_CMD;
            discarding_next = 1'b1;
          end
        end
      endcase
    end

    if (eot) begin
      phase_next      = PH_CMD;
      discarding_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CMD;
      command    <= '0;
      first_arg  <= '0;
      discarding <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      command    <= command_next;
      first_arg  <= first_arg_next;
      discarding <= discarding_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/grid_ring_event_parser.sv
`default_nettype none

// Decodes a received byte stream into grid key, ring delta and ring key
// events. One byte is taken per cycle unless the input stalls; a byte is
// decoded while it sits in the input register, and its event (if any) is
// then captured in the result register. The input stalls only when the
// byte in the input register completes a frame while a previous event is
// still held by a stalled output; bytes that yield no event keep flowing
// meanwhile.

`include "assert_macros.svh"

module grid_ring_event_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  output logic                    rx_stall,
  input  wire grep_pkg::rx_word_t rx_word,
  output logic                    ev_valid,
  input  wire logic               ev_stall,
  output grep_pkg::ev_word_t      ev_word
);
  import grep_pkg::*;

  logic     rx_q_valid;
  rx_word_t rx_q;
  logic     hit;
  ev_word_t ev;
  logic     out_free;
  logic     dec_go;
  logic     step;
  logic     take;

  assign out_free = !ev_valid || !ev_stall;
  assign dec_go   = !hit || out_free;
  assign rx_stall = rx_q_valid && !dec_go;
  assign take     = rx_valid && !rx_stall;
  assign step     = rx_q_valid && dec_go;

  grep_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .rx_in (rx_q),
    .hit   (hit),
    .ev    (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (!rx_stall) begin
      rx_q_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rx_q <= rx_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (out_free) begin
      ev_valid <= step && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit) begin
      ev_word <= ev;
    end
  end

  // input only holds back when a finished event is blocked downstream
  `GREP_ASSERT_NOW(a_stall_cause, rx_stall, ev_valid && ev_stall)
  // ring events carry a zero row
  `GREP_ASSERT_NOW(a_ring_row, ev_valid && (ev_word.event_kind != KIND_GRID_KEY), ev_word.pos_y == 8'd0)
  // key events carry up or down only
  `GREP_ASSERT_NOW(a_key_state, ev_valid && (ev_word.event_kind != KIND_RING_DELTA), (ev_word.event_value == 8'sd0) || (ev_word.event_value == 8'sd1))
  // a decoded event lands in the result register
  `GREP_ASSERT_NEXT(a_event_lands, step && hit, ev_valid)

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
  import grep_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int BYTE_TARGET = 1750;

  typedef enum logic [1:0] {WAIT_CMD, WAIT_ARG1, WAIT_ARG2} phase_e;

  class event_board;
    phase_e     phase;
    logic [7:0] held_cmd;
    logic [7:0] held_arg;
    bit         skipping;
    ev_word_t   pending_events[$];
    int         parsed_bytes;
    int         mismatches;

    function new();
      phase = WAIT_CMD;
      held_cmd = '0;
      held_arg = '0;
      skipping = 1'b0;
      parsed_bytes = 0;
      mismatches = 0;
    endfunction

    static function bit is_command(logic [7:0] b);
      return b == CMD_GRID_UP || b == CMD_GRID_DOWN || b == CMD_RING_DELTA ||
             b == CMD_RING_UP || b == CMD_RING_DOWN;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void note_byte(rx_word_t w);
      ev_word_t e;
      parsed_bytes++;
      if (skipping) begin
        if (w.end_of_transfer) begin
          skipping = 1'b0;
          phase = WAIT_CMD;
        end
        return;
      end
      case (phase)
        WAIT_ARG1: begin
          if (held_cmd == CMD_RING_UP || held_cmd == CMD_RING_DOWN) begin
            e.event_kind  = KIND_RING_KEY;
            e.pos_x       = w.rx_byte;
            e.pos_y       = '0;
            e.event_value = (held_cmd == CMD_RING_DOWN) ? 8'sd1 : 8'sd0;
            pending_events.push_back(e);
            phase = WAIT_CMD;
          end else if (held_cmd == CMD_GRID_UP || held_cmd == CMD_GRID_DOWN ||
                       held_cmd == CMD_RING_DELTA) begin
            held_arg = w.rx_byte;
            phase = WAIT_ARG2;
          end else begin
            phase = WAIT_CMD;
          end
        end
        WAIT_ARG2: begin
          if (held_cmd == CMD_GRID_UP || held_cmd == CMD_GRID_DOWN) begin
            e.event_kind  = KIND_GRID_KEY;
            e.pos_x       = held_arg;
            e.pos_y       = w.rx_byte;
            e.event_value = (held_cmd == CMD_GRID_DOWN) ? 8'sd1 : 8'sd0;
            pending_events.push_back(e);
          end else if (held_cmd == CMD_RING_DELTA) begin
            e.event_kind  = KIND_RING_DELTA;
            e.pos_x       = held_arg;
            e.pos_y       = '0;
            e.event_value = w.rx_byte;
            pending_events.push_back(e);
          end
          phase = WAIT_CMD;
        end
        default: begin
          if (is_command(w.rx_byte)) begin
            held_cmd = w.rx_byte;
            phase = WAIT_ARG1;
          end else begin
            phase = WAIT_CMD;
            skipping = 1'b1;
          end
        end
      endcase
      if (w.end_of_transfer) begin
        phase = WAIT_CMD;
        skipping = 1'b0;
      end
    endfunction

    function void check_event(ev_word_t got);
      ev_word_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d x %0d y %0d value %0d",
                   got.event_kind, got.pos_x, got.pos_y, got.event_value);
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.event_value !== want.event_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event mismatch: want kind %0d x %0d y %0d value %0d, got %0d %0d %0d %0d",
                   want.event_kind, want.pos_x, want.pos_y, want.event_value,
                   got.event_kind, got.pos_x, got.pos_y, got.event_value);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     rx_valid = 1'b0;
  logic     rx_stall;
  rx_word_t rx_word = '0;
  logic     ev_valid;
  logic     ev_stall = 1'b0;
  ev_word_t ev_word;

  event_board board;
  bit         hold_req = 1'b0;
  int         stuck_cycles = 0;

  always #5 clk = ~clk;

  grid_ring_event_parser dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_word  (rx_word),
    .ev_valid (ev_valid),
    .ev_stall (ev_stall),
    .ev_word  (ev_word)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_valid && !rx_stall) board.note_byte(rx_word);
      if (ev_valid && !ev_stall) board.check_event(ev_word);
      if ((rx_valid && !rx_stall) || (ev_valid && !ev_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // event sink: random stalls, a quiet stretch, and one long hold-off on request
  initial begin : event_sink
    int hold;
    int cyc;
    hold = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        cyc++;
        if (hold_req && hold == 0) begin
          hold = HOLD_CYCLES;
          hold_req = 1'b0;
        end
        if (hold > 0) begin
          hold--;
          ev_stall <= 1'b1;
        end else if (cyc > 150 && cyc < 600) begin
          ev_stall <= 1'b0;
        end else begin
          ev_stall <= ($urandom_range(99) < 12);
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    if (r < 20) return 8'h80;
    if (r < 24) return 8'h7F;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(4))
      0: return CMD_GRID_UP;
      1: return CMD_GRID_DOWN;
      2: return CMD_RING_DELTA;
      3: return CMD_RING_UP;
      default: return CMD_RING_DOWN;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot);
    rx_word_t w;
    w.rx_byte = b;
    w.end_of_transfer = eot;
    rx_valid <= 1'b1;
    rx_word <= w;
    do @(posedge clk); while (rx_stall);
    if ((board.parsed_bytes < 300 || board.parsed_bytes > 700) &&
        $urandom_range(99) < 12) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // one transfer: mostly well-formed frames, some unknown commands and noise,
  // sometimes cut short by the end of the transfer
  task automatic send_transfer();
    logic [7:0] q[$];
    int frames;
    int r;
    logic [7:0] c;
    frames = $urandom_range(1, 5);
    for (int f = 0; f < frames; f++) begin
      r = $urandom_range(99);
      if (r < 85) begin
        c = pick_command();
        q.push_back(c);
        q.push_back(rand_byte());
        if (c != CMD_RING_UP && c != CMD_RING_DOWN) q.push_back(rand_byte());
      end else if (r < 93) begin
        do c = 8'($urandom_range(255)); while (event_board::is_command(c));
        q.push_back(c);
        repeat ($urandom_range(0, 3)) q.push_back(rand_byte());
      end else begin
        q.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 15) begin
      c = pick_command();
      q.push_back(c);
      if (c != CMD_RING_UP && c != CMD_RING_DOWN && $urandom_range(1) == 1)
        q.push_back(rand_byte());
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin : stimulus
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(CMD_GRID_UP, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CMD_GRID_DOWN, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CMD_RING_DELTA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(CMD_RING_DELTA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(CMD_RING_UP, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(CMD_RING_DOWN, 1'b0);
    send_byte(8'hA5, 1'b1);
    // unknown command skips the rest of its transfer
    send_byte(8'hFF, 1'b0);
    send_byte(CMD_GRID_DOWN, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    // unknown command as the last word of a transfer
    send_byte(8'h00, 1'b1);
    // frames cut short
    send_byte(CMD_GRID_DOWN, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(CMD_RING_DELTA, 1'b1);
    wait_drain();

    while (board.parsed_bytes < BYTE_TARGET) begin
      if (!held && board.parsed_bytes >= 900) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && board.parsed_bytes >= 1300) begin
        wait_drain();
        drained = 1'b1;
      end
      send_transfer();
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
